// ----- sv/lzjb_pkg.sv -----
package lzjb_pkg;

	// History window: ten offset bits address 1024 bytes
	localparam int HIST_AW    = 10;
	localparam int HIST_DEPTH = 1 << HIST_AW;

	// Match length field: top six bits of the first match byte, biased by three
	localparam int LEN_SHIFT = 2;
	localparam int LEN_BIAS  = 3;
	localparam int LEN_W     = 7;

	localparam int OUT_LANES_DEF = 8;
	localparam int BYTE_W        = 8;

	typedef logic [HIST_AW-1:0] hist_addr_t;
	typedef logic [BYTE_W-1:0]  byte_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_TRUNC_CTRL  = 2'd1,
		ST_TRUNC_MATCH = 2'd2,
		ST_BAD_OFFSET  = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       last_in;
	} item_t;

	typedef struct packed {
		logic [63:0] out_data;
		logic [3:0]  out_count;
		status_t     status;
		logic        run_last;
		logic        block_end;
	} result_t;

endpackage

// ----- sv/lzjb_block_decompressor_top.sv -----
// LZJB block decompressor: one compressed byte per request, results in chunks of up to OUT_LANES bytes.
// A literal or error result is registered at the edge that accepts its byte.
// Flow: control, literal and first match bytes are taken while the copy sequencer is idle and
// the output register is free; a second match byte stalls the input until its copy is done:
// a history read (S_RD) and a history write (S_WR) per copied byte on the one RAM, an S_EMIT per chunk.
// Reset (arst_n low) clears parser, copy sequencer and output register; history is not reset.
module lzjb_block_decompressor_top #(
	parameter int OUT_LANES = lzjb_pkg::OUT_LANES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  lzjb_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output lzjb_pkg::result_t result
);
	import lzjb_pkg::*;

	localparam int CNT_W  = $clog2(OUT_LANES + 1);
	localparam int LANE_W = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1;
	localparam int PROD_W = HIST_AW + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RD,
		S_WR,
		S_EMIT
	} state_t;

	// Parser phase: item expected, item at flag zero after control, second match byte
	typedef enum logic [1:0] {
		PH_ITEM,
		PH_CTRL_DONE,
		PH_MATCH2
	} phase_t;

	state_t            state_q;
	phase_t            phase_q;
	hist_addr_t        wp_q;
	logic [PROD_W-1:0] prod_q;
	byte_t             flag_q;
	logic [2:0]        fpos_q;
	byte_t             fmb_q;
	logic              disc_q;

	// Copy sequencer
	logic [LEN_W-1:0]  rem_q;
	hist_addr_t        off_q;
	logic              last_q;
	logic [CNT_W-1:0]  cnt_q;
	byte_t             lane_q [OUT_LANES];

	logic              res_valid_q;
	result_t           res_q;

	// Decode of the incoming byte
	logic              out_free;
	logic              accept;
	logic [LEN_W-1:0]  len_w;
	hist_addr_t        off_w;
	logic              bad_off;
	logic [2:0]        pos_w;
	logic              ctrl_w;
	logic              flag_w;
	logic              lit_fire;
	logic              start_copy;
	logic              copy_done;
	logic              restart;
	logic [PROD_W-1:0] prod_inc;
	logic [63:0]       chunk_data;

	logic              mem_wr_en;
	byte_t             mem_wr_data;
	hist_addr_t        mem_rd_addr;
	byte_t             mem_rd_data;

	always_comb begin
		out_free   = !res_valid_q || !result_stall;
		item_stall = !(state_q == S_IDLE && out_free);
		accept     = item_valid && !item_stall;

		len_w   = LEN_W'(fmb_q[7:LEN_SHIFT]) + LEN_W'(LEN_BIAS);
		off_w   = {fmb_q[1:0], item.in_byte};
		bad_off = (off_w == '0) || (PROD_W'(off_w) > prod_q);

		pos_w    = (phase_q == PH_CTRL_DONE) ? 3'd0 : fpos_q + 3'd1;
		ctrl_w   = (phase_q != PH_CTRL_DONE) && (pos_w == 3'd0);
		flag_w   = flag_q[pos_w];
		lit_fire = !disc_q && (phase_q != PH_MATCH2) && !ctrl_w && !flag_w;

		start_copy = accept && !disc_q && (phase_q == PH_MATCH2) && !bad_off;
		copy_done  = (state_q == S_EMIT) && out_free && (rem_q == '0);
		restart    = (accept && item.last_in && !start_copy) || (copy_done && last_q);

		// Produced count saturates at the window size
		prod_inc = (prod_q == PROD_W'(HIST_DEPTH)) ? prod_q : prod_q + 1'b1;

		chunk_data = '0;
		for (int i = 0; i < OUT_LANES; i++) begin
			chunk_data[8*i +: 8] = lane_q[i];
		end

		mem_wr_en   = (accept && lit_fire) || (state_q == S_WR);
		mem_wr_data = (state_q == S_WR) ? mem_rd_data : item.in_byte;
		mem_rd_addr = wp_q - off_q;
	end

	lzjb_hist u_hist (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (wp_q),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_ITEM;
			wp_q        <= '0;
			prod_q      <= '0;
			flag_q      <= '0;
			fpos_q      <= 3'd7;
			fmb_q       <= '0;
			disc_q      <= 1'b0;
			rem_q       <= '0;
			off_q       <= '0;
			last_q      <= 1'b0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
			for (int i = 0; i < OUT_LANES; i++) begin
				lane_q[i] <= '0;
			end
		end else begin
			// Drop the result once taken
			if (!result_stall) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept && !disc_q) begin
						if (phase_q == PH_MATCH2) begin
							phase_q <= PH_ITEM;
							if (bad_off) begin
								// Report once, then discard the rest of the block
								res_valid_q     <= 1'b1;
								res_q           <= '0;
								res_q.status    <= ST_BAD_OFFSET;
								res_q.run_last  <= 1'b1;
								res_q.block_end <= 1'b1;
								disc_q          <= 1'b1;
							end else begin
								rem_q   <= len_w;
								off_q   <= off_w;
								last_q  <= item.last_in;
								cnt_q   <= '0;
								state_q <= S_RD;
							end
						end else if (ctrl_w) begin
							flag_q  <= item.in_byte;
							phase_q <= PH_CTRL_DONE;
							if (item.last_in) begin
								res_valid_q     <= 1'b1;
								res_q           <= '0;
								res_q.status    <= ST_TRUNC_CTRL;
								res_q.run_last  <= 1'b1;
								res_q.block_end <= 1'b1;
							end
						end else begin
							fpos_q  <= pos_w;
							phase_q <= PH_ITEM;
							if (flag_w) begin
								fmb_q   <= item.in_byte;
								phase_q <= PH_MATCH2;
								if (item.last_in) begin
									res_valid_q     <= 1'b1;
									res_q           <= '0;
									res_q.status    <= ST_TRUNC_MATCH;
									res_q.run_last  <= 1'b1;
									res_q.block_end <= 1'b1;
								end
							end else begin
								// Literal: store in history and pass straight out
								wp_q            <= wp_q + 1'b1;
								prod_q          <= prod_inc;
								res_valid_q     <= 1'b1;
								res_q.out_data  <= 64'(item.in_byte);
								res_q.out_count <= 4'd1;
								res_q.status    <= ST_OK;
								res_q.run_last  <= 1'b1;
								res_q.block_end <= item.last_in;
							end
						end
					end
				end
				S_RD: begin
					// Read address goes to the history this cycle
					state_q <= S_WR;
				end
				S_WR: begin
					// Append the copied byte and write it back behind the pointer
					lane_q[cnt_q[LANE_W-1:0]] <= mem_rd_data;
					cnt_q  <= cnt_q + 1'b1;
					rem_q  <= rem_q - 1'b1;
					wp_q   <= wp_q + 1'b1;
					prod_q <= prod_inc;
					if (cnt_q == CNT_W'(OUT_LANES - 1) || rem_q == LEN_W'(1)) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_RD;
					end
				end
				S_EMIT: begin
					// Hold the chunk until the output register frees up
					if (out_free) begin
						res_valid_q     <= 1'b1;
						res_q.out_data  <= chunk_data;
						res_q.out_count <= 4'(cnt_q);
						res_q.status    <= ST_OK;
						res_q.run_last  <= (rem_q == '0);
						res_q.block_end <= (rem_q == '0) && last_q;
						cnt_q           <= '0;
						for (int i = 0; i < OUT_LANES; i++) begin
							lane_q[i] <= '0;
						end
						state_q <= (rem_q == '0) ? S_IDLE : S_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// Block end or discard end: return the parser to its start state
			if (accept && disc_q && item.last_in) begin
				disc_q <= 1'b0;
			end
			if (restart) begin
				wp_q    <= '0;
				prod_q  <= '0;
				flag_q  <= '0;
				fpos_q  <= 3'd7;
				phase_q <= PH_ITEM;
				fmb_q   <= '0;
				disc_q  <= 1'b0;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

// ----- sv/lzjb_hist.sv -----
module lzjb_hist (
	input  logic               clk,
	input  logic               wr_en,
	input  lzjb_pkg::hist_addr_t wr_addr,
	input  lzjb_pkg::byte_t    wr_data,
	input  lzjb_pkg::hist_addr_t rd_addr,
	output lzjb_pkg::byte_t    rd_data
);
	import lzjb_pkg::*;

	byte_t mem_q [HIST_DEPTH];
	byte_t rd_data_q;

	// Read returns the contents before a write at the same edge
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- dv/lzjb_block_decompressor_checker.sv -----
module lzjb_block_decompressor_checker #(
	parameter int OUT_LANES = lzjb_pkg::OUT_LANES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  logic              item_stall,
	input  lzjb_pkg::item_t   item,
	input  logic              result_valid,
	input  logic              result_stall,
	input  lzjb_pkg::result_t result,
	output int                mismatches,
	output int                outstanding
);
	import lzjb_pkg::*;

	typedef enum logic [1:0] {
		PH_CTRL_OR_ITEM,
		PH_FIRST_ITEM,
		PH_MATCH_LOW
	} parse_phase_t;

	result_t      expected_chunks[$];

	byte_t        hist_mem[HIST_DEPTH];
	hist_addr_t   wr_ptr;
	logic [10:0]  produced;
	byte_t        flags;
	logic [2:0]   flag_pos;
	parse_phase_t phase;
	byte_t        match_hi;
	logic         discarding;

	function automatic void restart_block();
		wr_ptr   = '0;
		produced = '0;
		flags    = '0;
		flag_pos = 3'd7;
		phase    = PH_CTRL_OR_ITEM;
		match_hi = '0;
	endfunction

	function automatic void store_byte(byte_t b);
		hist_mem[wr_ptr] = b;
		wr_ptr = wr_ptr + 1'b1;
		if (produced < HIST_DEPTH)
			produced = produced + 1'b1;
	endfunction

	function automatic void push_chunk(logic [63:0] data, logic [3:0] count, status_t st,
			logic rl, logic be);
		result_t r;
		r.out_data  = data;
		r.out_count = count;
		r.status    = st;
		r.run_last  = rl;
		r.block_end = be;
		expected_chunks = {expected_chunks, r};
	endfunction

	// Advance the decoder by one compressed byte and queue the chunks it yields
	function automatic void decode_byte(item_t req);
		logic [2:0]  pos;
		int unsigned len;
		int unsigned off;
		int unsigned done;
		int unsigned cnt;
		logic [63:0] data;
		byte_t       v;

		if (discarding) begin
			if (req.last_in) begin
				discarding = 1'b0;
				restart_block();
			end
			return;
		end

		if (phase == PH_MATCH_LOW) begin
			len   = (match_hi >> LEN_SHIFT) + LEN_BIAS;
			off   = {match_hi[1:0], req.in_byte};
			phase = PH_CTRL_OR_ITEM;
			if (off == 0 || off > produced) begin
				push_chunk('0, '0, ST_BAD_OFFSET, 1'b1, 1'b1);
				if (req.last_in)
					restart_block();
				else
					discarding = 1'b1;
				return;
			end
			done = 0;
			while (done < len) begin
				data = '0;
				cnt  = 0;
				while (cnt < OUT_LANES && done < len) begin
					v = hist_mem[hist_addr_t'(wr_ptr - off)];
					store_byte(v);
					data[8*cnt +: 8] = v;
					cnt++;
					done++;
				end
				push_chunk(data, 4'(cnt), ST_OK, done == len, (done == len) && req.last_in);
			end
			if (req.last_in)
				restart_block();
			return;
		end

		if (phase == PH_FIRST_ITEM) begin
			pos = 3'd0;
		end else begin
			pos = flag_pos + 3'd1;
			if (pos == 3'd0) begin
				flags = req.in_byte;
				phase = PH_FIRST_ITEM;
				if (req.last_in) begin
					push_chunk('0, '0, ST_TRUNC_CTRL, 1'b1, 1'b1);
					restart_block();
				end
				return;
			end
		end

		flag_pos = pos;
		phase    = PH_CTRL_OR_ITEM;
		if (flags[pos]) begin
			if (req.last_in) begin
				push_chunk('0, '0, ST_TRUNC_MATCH, 1'b1, 1'b1);
				restart_block();
				return;
			end
			match_hi = req.in_byte;
			phase    = PH_MATCH_LOW;
			return;
		end

		store_byte(req.in_byte);
		push_chunk({56'h0, req.in_byte}, 4'd1, ST_OK, 1'b1, req.last_in);
		if (req.last_in)
			restart_block();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t exp_chunk;
		if (!arst_n) begin
			expected_chunks.delete();
			discarding  = 1'b0;
			restart_block();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			// compare first: a chunk leaving now was caused by an earlier request
			if (result_valid && !result_stall) begin
				if (expected_chunks.size() == 0) begin
					$error("unexpected chunk: out_data %h out_count %0d status %0d",
						result.out_data, result.out_count, result.status);
					mismatches++;
				end else begin
					exp_chunk = expected_chunks.pop_front();
					if (result.out_data !== exp_chunk.out_data) begin
						$error("out_data: expected %h, actual %h",
							exp_chunk.out_data, result.out_data);
						mismatches++;
					end
					if (result.out_count !== exp_chunk.out_count) begin
						$error("out_count: expected %0d, actual %0d",
							exp_chunk.out_count, result.out_count);
						mismatches++;
					end
					if (result.status !== exp_chunk.status) begin
						$error("status: expected %0d, actual %0d",
							exp_chunk.status, result.status);
						mismatches++;
					end
					if (result.run_last !== exp_chunk.run_last) begin
						$error("run_last: expected %0d, actual %0d",
							exp_chunk.run_last, result.run_last);
						mismatches++;
					end
					if (result.block_end !== exp_chunk.block_end) begin
						$error("block_end: expected %0d, actual %0d",
							exp_chunk.block_end, result.block_end);
						mismatches++;
					end
				end
			end
			if (item_valid && !item_stall)
				decode_byte(item);
			outstanding = expected_chunks.size();
		end
	end

endmodule

// ----- dv/lzjb_block_decompressor_top_tb.sv -----
module lzjb_block_decompressor_top_tb;
	import lzjb_pkg::*;

	// A long match holds the input while its bytes are copied; drain for
	// comfortably longer than that once nothing is outstanding.
	localparam int DRAIN_CYCLES = 400;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int TOTAL_ITEMS  = 160;

	typedef enum int {
		BLK_PLAIN,
		BLK_LONG,
		BLK_CUT_CTRL,
		BLK_CUT_MATCH,
		BLK_BAD_OFFSET,
		BLK_NOISE
	} block_kind_t;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	int          mismatches;
	int          outstanding;
	int          tx_idle_pct = 31;
	int          rx_idle_pct = 67;
	int          sent_count  = 0;
	int unsigned cycle_count = 0;

	// Compressed block under construction, and the encoder's view of it
	byte_t blk[$];
	int    gen_ctrl_idx;
	int    gen_slot;
	int    gen_produced;

	lzjb_block_decompressor_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	lzjb_block_decompressor_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Stall the result side at random; the percentage follows the idling phase
	always @(posedge clk) begin
		result_stall <= arst_n && ($urandom_range(99) < rx_idle_pct);
	end

	// Watchdog: give up well beyond the slowest legal run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL lzjb_block_decompressor_top");
			$finish;
		end
	end

	function automatic void add_byte(byte_t b);
		blk = {blk, b};
	endfunction

	// Claim the next flag of the current control byte, opening a new group
	// after eight flags. Unused flags of the last group keep random values.
	function automatic void next_slot(bit as_match);
		if (gen_slot == 8) begin
			gen_ctrl_idx = blk.size();
			add_byte(byte_t'($urandom));
			gen_slot = 0;
		end
		if (as_match)
			blk[gen_ctrl_idx] = blk[gen_ctrl_idx] | byte_t'(1 << gen_slot);
		else
			blk[gen_ctrl_idx] = blk[gen_ctrl_idx] & ~byte_t'(1 << gen_slot);
		gen_slot++;
	endfunction

	function automatic void add_literal();
		next_slot(1'b0);
		add_byte(byte_t'($urandom));
		gen_produced++;
	endfunction

	// Append a legal match: offset from 1 up to the bytes written so far, at most 1023
	function automatic void add_match(int len);
		int lim;
		int off;
		lim = (gen_produced > 1023) ? 1023 : gen_produced;
		case ($urandom_range(3))
			0:       off = lim;
			1:       off = $urandom_range((lim < 4) ? lim : 4, 1);
			default: off = $urandom_range(lim, 1);
		endcase
		next_slot(1'b1);
		add_byte(byte_t'(((len - LEN_BIAS) << LEN_SHIFT) | (off >> 8)));
		add_byte(byte_t'(off));
		gen_produced += len;
	endfunction

	function automatic void build_block(block_kind_t kind);
		int tokens;
		int match_pct;
		int off;
		blk.delete();
		gen_slot     = 8;
		gen_produced = 0;

		if (kind == BLK_NOISE) begin
			repeat ($urandom_range(12, 1))
				add_byte(byte_t'($urandom));
			return;
		end

		case (kind)
			BLK_PLAIN: tokens = $urandom_range(14, 1);
			BLK_LONG:  tokens = $urandom_range(40, 20);
			default:   tokens = $urandom_range(6, 0);
		endcase
		match_pct = (kind == BLK_LONG) ? 85 : 45;

		for (int n = 0; n < tokens; n++) begin
			if (gen_produced > 0 && $urandom_range(99) < match_pct) begin
				if (kind == BLK_LONG)
					add_match($urandom_range(66, 40));
				else if ($urandom_range(5) == 0)
					add_match($urandom_range(66, 3));
				else
					add_match($urandom_range(10, 3));
			end else begin
				add_literal();
			end
		end

		case (kind)
			BLK_CUT_CTRL: begin
				// fill the group so that the block ends on a control byte
				while (gen_slot != 8)
					add_literal();
				add_byte(byte_t'($urandom));
			end
			BLK_CUT_MATCH: begin
				next_slot(1'b1);
				add_byte(byte_t'($urandom));
			end
			BLK_BAD_OFFSET: begin
				if (gen_produced >= 1023 || $urandom_range(1) == 0)
					off = 0;
				else
					off = $urandom_range(1023, gen_produced + 1);
				next_slot(1'b1);
				add_byte(byte_t'(($urandom_range(63) << LEN_SHIFT) | (off >> 8)));
				add_byte(byte_t'(off));
				// trailing bytes that the decoder must drop
				repeat ($urandom_range(5))
					add_byte(byte_t'($urandom));
			end
			default: ;
		endcase
	endfunction

	// Offer one request, idling first at random, and hold it until taken.
	// The idling phase follows the number of requests sent so far.
	task automatic send_request(byte_t b, logic last);
		if (sent_count < TOTAL_ITEMS / 3) begin
			tx_idle_pct = 31;
			rx_idle_pct = 67;
		end else if (sent_count < 2 * TOTAL_ITEMS / 3) begin
			tx_idle_pct = 67;
			rx_idle_pct = 31;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
		while ($urandom_range(99) < tx_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid    <= 1'b1;
		item.in_byte  <= b;
		item.last_in  <= last;
		do
			@(posedge clk);
		while (item_stall);
		sent_count++;
	endtask

	task automatic send_block();
		for (int i = 0; i < blk.size(); i++)
			send_request(blk[i], i == blk.size() - 1);
	endtask

	initial begin
		int          pick;
		block_kind_t kind;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Literal 0xFF, then the longest match at offset one: 66 overlapping
		// copies in nine chunks, then a zero literal closing the block.
		blk = '{8'h02, 8'hFF, 8'hFC, 8'h01, 8'h00};
		send_block();
		// Block made of nothing but a control byte
		blk = '{8'h00};
		send_block();
		// Block ending on the first byte of a match
		blk = '{8'h01, 8'h00};
		send_block();
		// Offset zero, then a byte to discard before the block ends
		blk = '{8'h02, 8'h41, 8'h00, 8'h00, 8'h37};
		send_block();
		// Largest offset with nothing produced yet, on the final byte
		blk = '{8'h01, 8'h03, 8'hFF};
		send_block();
		// Seven literals, then a shortest match on the top flag
		blk = '{8'h80, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'hAA, 8'h00, 8'h07};
		send_block();

		// Random blocks: mostly well formed, some cut short, broken or noise
		while (sent_count < TOTAL_ITEMS) begin
			pick = $urandom_range(99);
			if (pick < 56)
				kind = BLK_PLAIN;
			else if (pick < 66)
				kind = BLK_LONG;
			else if (pick < 74)
				kind = BLK_CUT_CTRL;
			else if (pick < 82)
				kind = BLK_CUT_MATCH;
			else if (pick < 92)
				kind = BLK_BAD_OFFSET;
			else
				kind = BLK_NOISE;
			build_block(kind);
			send_block();
		end
		item_valid <= 1'b0;

		// Let the checker take in the final request, then drain
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("PASS lzjb_block_decompressor_top");
		else
			$display("FAIL lzjb_block_decompressor_top");
		$finish;
	end

endmodule
